[sv/rca_pkg.sv]
// rca_pkg: shared constants, codes, types and the pass table of the register class allocator
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package rca_pkg;

   // sizes
   localparam int NUM_REGS  = 16;
   localparam int REG_W     = 16;
   localparam int IDX_W     = 4;
   localparam int PRIO_W    = 8;
   localparam int FLAG_W    = 5;
   localparam int NUM_SLOTS = 7;
   localparam int SLOT_W    = 3;
   localparam int CMD_W     = 3;
   localparam int HINT_W    = 3;
   localparam int ERR_W     = 2;
   localparam int CSR_AW    = 6;
   localparam int CSR_DW    = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [REG_W-1:0] REG_ALL = REG_W'((1 << NUM_REGS) - 1);
   localparam logic [IDX_W-1:0] SCAN_LAST_IDX = IDX_W'(NUM_REGS - 1);

   // commands
   localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ACQUIRE     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DISCARD     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_GRAB        = 3'd3;
   localparam logic [CMD_W-1:0] CMD_UNGRAB      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_PICK        = 3'd5;
   localparam logic [CMD_W-1:0] CMD_PICK_UNUSED = 3'd6;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd1;
   localparam logic [ERR_W-1:0] ERR_CONFLICT = 2'd2;
   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd3;

   // hint bit positions
   localparam int HINT_JUMP_ADDR = 0;
   localparam int HINT_JUMP_HASH = 1;
   localparam int HINT_CALL_LIVE = 2;

   // per register flags
   localparam logic [FLAG_W-1:0] FL_NONE = 5'b00000;
   localparam logic [FLAG_W-1:0] FL_P    = 5'b00001;
   localparam logic [FLAG_W-1:0] FL_X    = 5'b00010;
   localparam logic [FLAG_W-1:0] FL_R    = 5'b00100;
   localparam logic [FLAG_W-1:0] FL_D    = 5'b01000;
   localparam logic [FLAG_W-1:0] FL_H    = 5'b10000;

   // pass slots, in priority order
   localparam logic [SLOT_W-1:0] SLOT_PC       = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_HASH     = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_A        = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_B        = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_C        = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_D        = 3'd5;
   localparam logic [SLOT_W-1:0] SLOT_FALLBACK = 3'd6;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKED    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESERVED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REX       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RETURN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_PC   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_HASH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIO_LO   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIO_HI   = 3'd7;

   typedef struct packed {
      logic [REG_W-1:0]  locked;
      logic [REG_W-1:0]  preserved;
      logic [REG_W-1:0]  rex;
      logic [REG_W-1:0]  ret;
      logic [REG_W-1:0]  disp_pc;
      logic [REG_W-1:0]  disp_hash;
      logic [CSR_DW-1:0] prio_lo;
      logic [CSR_DW-1:0] prio_hi;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic              fallback;
      logic [FLAG_W-1:0] want;
      logic [FLAG_W-1:0] mask;
   } rule_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_pick;
      logic scan_last;
      logic out_free;
   } ctrl_status_type;

   // flag/mask pass of one slot, a pass matching when (flags & mask) == want
   function automatic rule_type slot_rule(input logic [SLOT_W-1:0] slot,
                                          input logic [HINT_W-1:0] hint,
                                          input logic [CMD_W-1:0]  cmd);
      rule_type r;
      logic     live;
      r    = '0;
      live = hint[HINT_CALL_LIVE];
      case (slot)
         SLOT_PC: begin
            r.en = hint[HINT_JUMP_ADDR]; r.want = FL_D; r.mask = FL_D;
         end
         SLOT_HASH: begin
            r.en = hint[HINT_JUMP_HASH]; r.want = FL_H; r.mask = FL_H;
         end
         SLOT_A: begin
            r.en   = 1'b1;
            r.want = live ? FL_P : FL_R;
            r.mask = live ? (FL_P | FL_X | FL_R) : (FL_R | FL_X);
         end
         SLOT_B: begin
            // the call-free variant can never match; kept for order
            r.en   = 1'b1;
            r.want = FL_P;
            r.mask = live ? (FL_P | FL_R) : FL_X;
         end
         SLOT_C: begin
            r.en   = 1'b1;
            r.want = FL_NONE;
            r.mask = live ? (FL_X | FL_R) : FL_P;
         end
         SLOT_D: begin
            r.en   = 1'b1;
            r.want = FL_NONE;
            r.mask = live ? FL_R : FL_NONE;
         end
         SLOT_FALLBACK: begin
            r.en = (cmd == CMD_PICK); r.fallback = 1'b1;
            r.want = FL_NONE; r.mask = FL_NONE;
         end
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/rca_req_if.sv]
// rca_req_if: command channel of the register class allocator
// depends on rca_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rca_req_if;
   import rca_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [IDX_W-1:0]  reg_index;
   logic [HINT_W-1:0] hint_bits;

   modport source (output valid, cmd, reg_index, hint_bits, input ready);
   modport sink (input valid, cmd, reg_index, hint_bits, output ready);
endinterface

`default_nettype wire

[sv/rca_rsp_if.sv]
// rca_rsp_if: result channel of the register class allocator
// depends on rca_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rca_rsp_if;
   import rca_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] picked_index;
   logic             found;
   logic [ERR_W-1:0] error_code;
   logic             addressed_in_use;
   logic             addressed_grabbed;

   modport source (output valid, picked_index, found, error_code, addressed_in_use,
                   addressed_grabbed, input ready);
   modport sink (input valid, picked_index, found, error_code, addressed_in_use,
                 addressed_grabbed, output ready);
endinterface

`default_nettype wire

[sv/rca_csr.sv]
// rca_csr: configuration register file with its apb-style port
// depends on rca_pkg
`timescale 1ns / 1ps
`default_nettype none

module rca_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rca_pkg::CSR_AW-1:0]  paddr,
   input  logic [rca_pkg::CSR_DW-1:0]  pwdata,
   output logic [rca_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output rca_pkg::cfg_type            cfg
);
   import rca_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic [CSR_IDX_W-1:0] sel_idx;
   logic                 wr_en;

   assign pready  = 1'b1;
   assign sel_idx = paddr[CSR_AW-1:CSR_AW-CSR_IDX_W];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel_idx)
            CSR_LOCKED:    cfg_in.locked    = pwdata[REG_W-1:0];
            CSR_PRESERVED: cfg_in.preserved = pwdata[REG_W-1:0];
            CSR_REX:       cfg_in.rex       = pwdata[REG_W-1:0];
            CSR_RETURN:    cfg_in.ret       = pwdata[REG_W-1:0];
            CSR_DISP_PC:   cfg_in.disp_pc   = pwdata[REG_W-1:0];
            CSR_DISP_HASH: cfg_in.disp_hash = pwdata[REG_W-1:0];
            CSR_PRIO_LO:   cfg_in.prio_lo   = pwdata;
            CSR_PRIO_HI:   cfg_in.prio_hi   = pwdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel_idx)
         CSR_LOCKED:    prdata = CSR_DW'(cfg_ff.locked);
         CSR_PRESERVED: prdata = CSR_DW'(cfg_ff.preserved);
         CSR_REX:       prdata = CSR_DW'(cfg_ff.rex);
         CSR_RETURN:    prdata = CSR_DW'(cfg_ff.ret);
         CSR_DISP_PC:   prdata = CSR_DW'(cfg_ff.disp_pc);
         CSR_DISP_HASH: prdata = CSR_DW'(cfg_ff.disp_hash);
         CSR_PRIO_LO:   prdata = cfg_ff.prio_lo;
         CSR_PRIO_HI:   prdata = cfg_ff.prio_hi;
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[sv/rca_ctrl.sv]
// rca_ctrl: sequencer of the register class allocator (accept, scan, finish)
// depends on rca_pkg
`timescale 1ns / 1ps
`default_nettype none

module rca_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rca_pkg::ctrl_status_type status,
   output rca_pkg::ctrl_cmd_type    cmd
);
   import rca_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one register per cycle for picks, straight through otherwise
            cmd.scan = status.is_pick;
            if (!status.is_pick || status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[sv/rca_dp.sv]
// rca_dp: datapath of the register class allocator: marks, pick scan, result register
// depends on rca_pkg
`timescale 1ns / 1ps
`default_nettype none

module rca_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rca_pkg::cfg_type              cfg,
   input  rca_pkg::ctrl_cmd_type         cmd,
   output rca_pkg::ctrl_status_type      status,
   input  logic [rca_pkg::CMD_W-1:0]     req_cmd,
   input  logic [rca_pkg::IDX_W-1:0]     req_reg_index,
   input  logic [rca_pkg::HINT_W-1:0]    req_hint_bits,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rca_pkg::IDX_W-1:0]     rsp_picked_index,
   output logic                          rsp_found,
   output logic [rca_pkg::ERR_W-1:0]     rsp_error_code,
   output logic                          rsp_addressed_in_use,
   output logic                          rsp_addressed_grabbed
);
   import rca_pkg::*;

   // latched item
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [HINT_W-1:0] hint_ff, hint_in;

   // marks
   logic [REG_W-1:0] in_use_ff, in_use_in;
   logic [REG_W-1:0] grabbed_ff, grabbed_in;

   // scan position and per-slot best so far
   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic [NUM_SLOTS-1:0]     best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]         best_idx_ff [NUM_SLOTS];
   logic [IDX_W-1:0]         best_idx_in [NUM_SLOTS];
   logic signed [PRIO_W-1:0] best_prio_ff [NUM_SLOTS];
   logic signed [PRIO_W-1:0] best_prio_in [NUM_SLOTS];

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] picked_ff, picked_in;
   logic             found_ff, found_in;
   logic [ERR_W-1:0] err_ff, err_in;
   logic             addr_use_ff, addr_use_in;
   logic             addr_grab_ff, addr_grab_in;

   // scan terms
   rule_type                 rules [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]     cand;
   logic [FLAG_W-1:0]        cur_flags;
   logic [CSR_DW-1:0]        prio_word;
   logic signed [PRIO_W-1:0] cur_prio;
   logic                     cur_avail;
   logic                     cur_fb_avail;

   // finish terms
   logic             res_found;
   logic [IDX_W-1:0] res_idx;
   logic             in_range;
   logic [REG_W-1:0] sel_bit;
   logic             is_pick;

   assign is_pick = (cmd_ff == CMD_PICK) || (cmd_ff == CMD_PICK_UNUSED);
   assign in_range = ({1'b0, idx_ff} < (IDX_W + 1)'(NUM_REGS));
   assign sel_bit  = REG_W'(1) << idx_ff;

   assign status.is_pick   = is_pick;
   assign status.scan_last = (scan_ff == SCAN_LAST_IDX);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // flags and priority of the register under the scan
   assign cur_flags = {cfg.disp_hash[scan_ff], cfg.disp_pc[scan_ff], cfg.ret[scan_ff],
                       cfg.rex[scan_ff], cfg.preserved[scan_ff]};
   assign prio_word = scan_ff[IDX_W-1] ? cfg.prio_hi : cfg.prio_lo;
   assign cur_prio  = prio_word[{scan_ff[IDX_W-2:0], 3'b000} +: PRIO_W];
   assign cur_fb_avail = !cfg.locked[scan_ff] && !grabbed_ff[scan_ff];
   assign cur_avail    = cur_fb_avail && !in_use_ff[scan_ff];

   always_comb begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
         rules[s] = slot_rule(SLOT_W'(s), hint_ff, cmd_ff);
         cand[s]  = rules[s].en && (rules[s].fallback ? cur_fb_avail : cur_avail)
                    && ((cur_flags & rules[s].mask) == rules[s].want);
      end
   end

   // first slot in pass order that holds a register
   always_comb begin
      res_found = 1'b0;
      res_idx   = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (best_vld_ff[s]) begin
            res_found = 1'b1;
            res_idx   = best_idx_ff[s];
         end
      end
   end

   always_comb begin
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      hint_in      = hint_ff;
      in_use_in    = in_use_ff;
      grabbed_in   = grabbed_ff;
      scan_in      = scan_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_prio_in = best_prio_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      picked_in    = picked_ff;
      found_in     = found_ff;
      err_in       = err_ff;
      addr_use_in  = addr_use_ff;
      addr_grab_in = addr_grab_ff;

      if (cmd.load) begin
         cmd_in      = req_cmd;
         idx_in      = req_reg_index;
         hint_in     = req_hint_bits;
         scan_in     = '0;
         best_vld_in = '0;
      end

      if (cmd.scan) begin
         scan_in = scan_ff + IDX_W'(1);
         for (int s = 0; s < NUM_SLOTS; s++) begin
            // strict compare keeps the lowest index on a tie
            if (cand[s] && (!best_vld_ff[s] || cur_prio > best_prio_ff[s])) begin
               best_vld_in[s]  = 1'b1;
               best_idx_in[s]  = scan_ff;
               best_prio_in[s] = cur_prio;
            end
         end
      end

      if (cmd.finish) begin
         picked_in = '0;
         found_in  = 1'b0;
         err_in    = ERR_OK;
         case (cmd_ff)
            CMD_CLEAR: begin
               in_use_in  = '0;
               grabbed_in = '0;
            end
            CMD_ACQUIRE: begin
               if (!in_range) err_in = ERR_RANGE;
               else if (|((in_use_ff | cfg.locked) & sel_bit)) err_in = ERR_CONFLICT;
               else in_use_in = in_use_ff | sel_bit;
            end
            CMD_DISCARD: begin
               if (!in_range) err_in = ERR_RANGE;
               else if (!(|(in_use_ff & sel_bit)) || (|(cfg.locked & sel_bit)))
                  err_in = ERR_CONFLICT;
               else in_use_in = in_use_ff & ~sel_bit;
            end
            CMD_GRAB: begin
               if (!in_range) err_in = ERR_RANGE;
               else if (|(grabbed_ff & sel_bit)) err_in = ERR_CONFLICT;
               else grabbed_in = grabbed_ff | sel_bit;
            end
            CMD_UNGRAB: begin
               if (!in_range) err_in = ERR_RANGE;
               else if (!(|(grabbed_ff & sel_bit))) err_in = ERR_CONFLICT;
               else grabbed_in = grabbed_ff & ~sel_bit;
            end
            CMD_PICK, CMD_PICK_UNUSED: begin
               if (res_found) begin
                  picked_in = res_idx;
                  found_in  = 1'b1;
               end else begin
                  err_in = ERR_NONE;
               end
            end
            default: err_in = ERR_OK;
         endcase
         addr_use_in  = in_range && in_use_in[idx_ff];
         addr_grab_in = in_range && grabbed_in[idx_ff];
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff    <= '0;
         grabbed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         best_vld_ff  <= '0;
         scan_ff      <= '0;
      end else begin
         in_use_ff    <= in_use_in & REG_ALL;
         grabbed_ff   <= grabbed_in & REG_ALL;
         rsp_valid_ff <= rsp_valid_in;
         best_vld_ff  <= best_vld_in;
         scan_ff      <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      hint_ff      <= hint_in;
      best_idx_ff  <= best_idx_in;
      best_prio_ff <= best_prio_in;
      picked_ff    <= picked_in;
      found_ff     <= found_in;
      err_ff       <= err_in;
      addr_use_ff  <= addr_use_in;
      addr_grab_ff <= addr_grab_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_picked_index      = picked_ff;
   assign rsp_found             = found_ff;
   assign rsp_error_code        = err_ff;
   assign rsp_addressed_in_use  = addr_use_ff;
   assign rsp_addressed_grabbed = addr_grab_ff;

endmodule

`default_nettype wire

[sv/register_class_allocator.sv]
// register_class_allocator: top level, joins the csr file, sequencer and datapath
// depends on rca_pkg, rca_req_if, rca_rsp_if, rca_csr, rca_ctrl, rca_dp
//
//   port       | dir   | handshake          | carries
//   -----------+-------+--------------------+---------------------------------------------
//   req_chan   | in    | valid / ready      | cmd, reg_index, hint_bits
//   rsp_chan   | out   | valid / ready      | picked_index, found, error_code, addressed marks
//   apb (p*)   | in    | psel/penable/ready | eight registers at byte address 8*i, 64-bit data
//
// a pick command goes from transfer to result through the accept edge, one cycle per
// register in the scan (sixteen, all passes tested in parallel) and the finish step;
// the other commands do not scan; the scan of one register per cycle sets the pick rate
// the next transfer is taken once an item has moved into the output register, even while
// that result still waits; a stalled result register holds the next item in its finish step
// reset is synchronous, clears the marks and all configuration, and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module register_class_allocator (
   input  logic                       clock,
   input  logic                       reset,
   rca_req_if.sink                    req_chan,
   rca_rsp_if.source                  rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rca_pkg::CSR_AW-1:0] paddr,
   input  logic [rca_pkg::CSR_DW-1:0] pwdata,
   output logic [rca_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import rca_pkg::*;

   cfg_type         cfg;
   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;

   // configuration registers, to be written only while the block is idle; the block itself does not enforce it
   rca_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer owns the input ready and steps the datapath
   rca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   // marks, pick scan and the result register
   rca_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .cmd                   (ctrl_cmd),
      .status                (ctrl_status),
      .req_cmd               (req_chan.cmd),
      .req_reg_index         (req_chan.reg_index),
      .req_hint_bits         (req_chan.hint_bits),
      .rsp_valid             (rsp_chan.valid),
      .rsp_ready             (rsp_chan.ready),
      .rsp_picked_index      (rsp_chan.picked_index),
      .rsp_found             (rsp_chan.found),
      .rsp_error_code        (rsp_chan.error_code),
      .rsp_addressed_in_use  (rsp_chan.addressed_in_use),
      .rsp_addressed_grabbed (rsp_chan.addressed_grabbed)
   );

endmodule

`default_nettype wire

[tb/register_class_allocator_tb.sv]
// register_class_allocator_tb: self-checking bench for the register class allocator
// drives commands, configuration writes and result back-pressure, predicts every result
// depends on rca_pkg, rca_req_if, rca_rsp_if and register_class_allocator
`timescale 1ns / 1ps

module register_class_allocator_tb;
   import rca_pkg::*;

   // the one command code the block leaves unused
   localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;

   localparam int RANDOM_PHASES    = 8;
   localparam int ITEMS_PER_PHASE  = 178;
   localparam int HOLD_CYCLES      = 400;
   localparam int TAIL_CYCLES      = 36;
   localparam int MAX_PRINTED      = 200;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // one result item as the block reports it
   typedef struct packed {
      logic [IDX_W-1:0] picked;
      logic             found;
      logic [ERR_W-1:0] err;
      logic             in_use;
      logic             grabbed;
   } alloc_outcome_type;

   // one row of the directed part: a command, or a register write
   typedef struct {
      logic                 is_write;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [CSR_DW-1:0]    csr_val;
      logic [CMD_W-1:0]     cmd;
      logic [IDX_W-1:0]     idx;
      logic [HINT_W-1:0]    hint;
      logic                 typed;
      alloc_outcome_type    outcome;
   } directed_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   rca_req_if req_bus ();
   rca_rsp_if rsp_bus ();

   logic result_ready = 1'b0;
   assign rsp_bus.ready = result_ready;

   register_class_allocator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the block's marks and configuration
   logic [REG_W-1:0] shadow_in_use  = '0;
   logic [REG_W-1:0] shadow_grabbed = '0;
   cfg_type          shadow_cfg     = '0;

   alloc_outcome_type awaited_outcomes[$];
   directed_step_type directed_steps[$];

   idle_mode_type idle_mode    = IDLE_NONE;
   logic       hold_request    = 1'b0;
   logic       hold_started    = 1'b0;
   int         hold_left       = 0;
   int         mismatch_count  = 0;
   int         results_checked = 0;
   int         items_sent      = 0;
   int         settings_applied = 0;

   // ---------------------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------------------

   // flag bits of one register: P, X, R, D, H from bit 0 up
   function automatic logic [FLAG_W-1:0] flags_of(input int r);
      return {shadow_cfg.disp_hash[r], shadow_cfg.disp_pc[r], shadow_cfg.ret[r],
              shadow_cfg.rex[r], shadow_cfg.preserved[r]};
   endfunction

   function automatic logic signed [PRIO_W-1:0] prio_of(input int r);
      logic [CSR_DW-1:0] w;
      w = (r < 8) ? shadow_cfg.prio_lo : shadow_cfg.prio_hi;
      return w[(r % 8) * PRIO_W +: PRIO_W];
   endfunction

   // highest priority in the set, lowest index on a tie
   function automatic logic best_index(input logic [REG_W-1:0] cand,
                                       output logic [IDX_W-1:0] choice);
      logic                     any;
      logic signed [PRIO_W-1:0] top;
      logic signed [PRIO_W-1:0] p;
      any    = 1'b0;
      top    = '0;
      choice = '0;
      for (int r = 0; r < NUM_REGS; r++) begin
         if (cand[r]) begin
            p = prio_of(r);
            if (!any || p > top) begin
               any    = 1'b1;
               top    = p;
               choice = IDX_W'(r);
            end
         end
      end
      return any;
   endfunction

   // one flag/mask pass over the registers that are free, unlocked and not grabbed
   function automatic logic try_pass(input logic [FLAG_W-1:0] want,
                                     input logic [FLAG_W-1:0] mask,
                                     output logic [IDX_W-1:0] choice);
      logic [REG_W-1:0] avail;
      logic [REG_W-1:0] cand;
      avail = REG_ALL & ~(shadow_in_use | shadow_cfg.locked | shadow_grabbed);
      cand  = '0;
      for (int r = 0; r < NUM_REGS; r++)
         if (avail[r] && ((flags_of(r) & mask) == want)) cand[r] = 1'b1;
      return best_index(cand, choice);
   endfunction

   function automatic logic pick_by_hints(input logic [HINT_W-1:0] hint,
                                          output logic [IDX_W-1:0] choice);
      choice = '0;
      if (hint[HINT_JUMP_ADDR] && try_pass(FL_D, FL_D, choice)) return 1'b1;
      if (hint[HINT_JUMP_HASH] && try_pass(FL_H, FL_H, choice)) return 1'b1;
      if (hint[HINT_CALL_LIVE]) begin
         if (try_pass(FL_P, FL_P | FL_X | FL_R, choice)) return 1'b1;
         if (try_pass(FL_P, FL_P | FL_R, choice)) return 1'b1;
         if (try_pass(FL_NONE, FL_X | FL_R, choice)) return 1'b1;
         if (try_pass(FL_NONE, FL_R, choice)) return 1'b1;
      end else begin
         if (try_pass(FL_R, FL_R | FL_X, choice)) return 1'b1;
         // never matches, kept so the order stays the block's
         if (try_pass(FL_P, FL_X, choice)) return 1'b1;
         if (try_pass(FL_NONE, FL_P, choice)) return 1'b1;
         if (try_pass(FL_NONE, FL_NONE, choice)) return 1'b1;
      end
      return 1'b0;
   endfunction

   // applies one command to the shadow state and returns the result it gives
   function automatic alloc_outcome_type predict_allocation(input logic [CMD_W-1:0]  cmd,
                                                            input logic [IDX_W-1:0]  idx,
                                                            input logic [HINT_W-1:0] hint);
      alloc_outcome_type o;
      logic              in_range;
      logic [REG_W-1:0]  sel;
      logic              hit;
      logic [IDX_W-1:0]  choice;
      o        = '0;
      in_range = (int'(idx) < NUM_REGS);
      sel      = REG_W'(1) << idx;
      case (cmd)
         CMD_CLEAR: begin
            shadow_in_use  = '0;
            shadow_grabbed = '0;
         end
         CMD_ACQUIRE: begin
            if (!in_range) o.err = ERR_RANGE;
            else if (((shadow_in_use | shadow_cfg.locked) & sel) != '0) o.err = ERR_CONFLICT;
            else shadow_in_use = shadow_in_use | sel;
         end
         CMD_DISCARD: begin
            if (!in_range) o.err = ERR_RANGE;
            else if ((shadow_in_use & sel) == '0 || (shadow_cfg.locked & sel) != '0)
               o.err = ERR_CONFLICT;
            else shadow_in_use = shadow_in_use & ~sel;
         end
         CMD_GRAB: begin
            if (!in_range) o.err = ERR_RANGE;
            else if ((shadow_grabbed & sel) != '0) o.err = ERR_CONFLICT;
            else shadow_grabbed = shadow_grabbed | sel;
         end
         CMD_UNGRAB: begin
            if (!in_range) o.err = ERR_RANGE;
            else if ((shadow_grabbed & sel) == '0) o.err = ERR_CONFLICT;
            else shadow_grabbed = shadow_grabbed & ~sel;
         end
         CMD_PICK, CMD_PICK_UNUSED: begin
            hit = pick_by_hints(hint, choice);
            // plain pick falls back to anything unlocked and not grabbed
            if (!hit && cmd == CMD_PICK)
               hit = best_index(REG_ALL & ~(shadow_cfg.locked | shadow_grabbed), choice);
            if (hit) begin
               o.picked = choice;
               o.found  = 1'b1;
            end else begin
               o.err = ERR_NONE;
            end
         end
         default: ;
      endcase
      o.in_use  = in_range ? shadow_in_use[idx] : 1'b0;
      o.grabbed = in_range ? shadow_grabbed[idx] : 1'b0;
      return o;
   endfunction

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic directed_step_type step_cmd(input logic [CMD_W-1:0]  cmd,
                                                  input logic [IDX_W-1:0]  idx,
                                                  input logic [HINT_W-1:0] hint);
      directed_step_type s;
      s      = '{default: '0};
      s.cmd  = cmd;
      s.idx  = idx;
      s.hint = hint;
      return s;
   endfunction

   function automatic directed_step_type step_typed(input logic [CMD_W-1:0]  cmd,
                                                    input logic [IDX_W-1:0]  idx,
                                                    input logic [HINT_W-1:0] hint,
                                                    input alloc_outcome_type outcome);
      directed_step_type s;
      s         = step_cmd(cmd, idx, hint);
      s.typed   = 1'b1;
      s.outcome = outcome;
      return s;
   endfunction

   function automatic directed_step_type step_write(input logic [CSR_IDX_W-1:0] csr_idx,
                                                    input logic [CSR_DW-1:0]    csr_val);
      directed_step_type s;
      s          = '{default: '0};
      s.is_write = 1'b1;
      s.csr_idx  = csr_idx;
      s.csr_val  = csr_val;
      return s;
   endfunction

   // random member of a set of registers, any register when the set is empty
   function automatic logic [IDX_W-1:0] random_member(input logic [REG_W-1:0] set);
      int n;
      int k;
      n = $countones(set);
      if (n == 0) return IDX_W'($urandom_range(NUM_REGS - 1));
      k = $urandom_range(n - 1);
      for (int r = 0; r < NUM_REGS; r++) begin
         if (set[r]) begin
            if (k == 0) return IDX_W'(r);
            k--;
         end
      end
      return '0;
   endfunction

   // priorities with many ties and extreme bytes
   function automatic logic [CSR_DW-1:0] random_prio_word();
      logic [CSR_DW-1:0] w;
      for (int b = 0; b < 8; b++) begin
         if ($urandom_range(1) == 0) begin
            case ($urandom_range(4))
               0: w[b*8 +: 8] = 8'h80;
               1: w[b*8 +: 8] = 8'hFF;
               2: w[b*8 +: 8] = 8'h00;
               3: w[b*8 +: 8] = 8'h01;
               default: w[b*8 +: 8] = 8'h7F;
            endcase
         end else begin
            w[b*8 +: 8] = 8'($urandom);
         end
      end
      return w;
   endfunction

   // mostly commands that succeed against the current marks, the rest random
   task automatic next_random_command(output logic [CMD_W-1:0]  cmd,
                                      output logic [IDX_W-1:0]  idx,
                                      output logic [HINT_W-1:0] hint);
      int   pct;
      logic steer;
      pct   = $urandom_range(99);
      steer = ($urandom_range(3) != 0);
      idx   = IDX_W'($urandom_range(NUM_REGS - 1));
      hint  = HINT_W'($urandom_range(7));
      if (pct < 4) begin
         cmd = CMD_CLEAR;
      end else if (pct < 22) begin
         cmd = CMD_ACQUIRE;
         if (steer) idx = random_member(~(shadow_in_use | shadow_cfg.locked));
      end else if (pct < 36) begin
         cmd = CMD_DISCARD;
         if (steer) idx = random_member(shadow_in_use & ~shadow_cfg.locked);
      end else if (pct < 48) begin
         cmd = CMD_GRAB;
         if (steer) idx = random_member(~shadow_grabbed);
      end else if (pct < 58) begin
         cmd = CMD_UNGRAB;
         if (steer) idx = random_member(shadow_grabbed);
      end else if (pct < 78) begin
         cmd = CMD_PICK;
      end else if (pct < 97) begin
         cmd = CMD_PICK_UNUSED;
      end else begin
         cmd = CMD_SPARE;
      end
   endtask

   // offers one command, waits for its transfer and queues the result it must give
   task automatic send_command(input logic [CMD_W-1:0]  cmd,
                               input logic [IDX_W-1:0]  idx,
                               input logic [HINT_W-1:0] hint,
                               input logic              typed,
                               input alloc_outcome_type typed_outcome);
      int                idle_pct;
      alloc_outcome_type predicted;
      idle_pct = (idle_mode == IDLE_SENDER) ? 62 : (idle_mode == IDLE_BOTH) ? 23 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.reg_index <= idx;
      req_bus.hint_bits <= hint;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = predict_allocation(cmd, idx, hint);
      awaited_outcomes.push_back(typed ? typed_outcome : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   // drops valid and waits until every queued result has come back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(negedge clock);
   endtask

   // setup and access phases, then the bus is released to idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] csr_idx,
                            input logic [CSR_DW-1:0]    value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'(8 * int'(csr_idx));
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (csr_idx)
         CSR_LOCKED:    shadow_cfg.locked    = value[REG_W-1:0];
         CSR_PRESERVED: shadow_cfg.preserved = value[REG_W-1:0];
         CSR_REX:       shadow_cfg.rex       = value[REG_W-1:0];
         CSR_RETURN:    shadow_cfg.ret       = value[REG_W-1:0];
         CSR_DISP_PC:   shadow_cfg.disp_pc   = value[REG_W-1:0];
         CSR_DISP_HASH: shadow_cfg.disp_hash = value[REG_W-1:0];
         CSR_PRIO_LO:   shadow_cfg.prio_lo   = value;
         CSR_PRIO_HI:   shadow_cfg.prio_hi   = value;
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // writes all eight registers; some phases sit at the extremes
   task automatic apply_setting(input int phase);
      logic [CSR_DW-1:0] v[8];
      v[CSR_LOCKED]    = CSR_DW'($urandom & $urandom & 32'hFFFF);
      v[CSR_PRESERVED] = CSR_DW'($urandom & 32'hFFFF);
      v[CSR_REX]       = CSR_DW'($urandom & 32'hFFFF);
      v[CSR_RETURN]    = CSR_DW'($urandom & 32'hFFFF);
      v[CSR_DISP_PC]   = CSR_DW'($urandom & 32'hFFFF);
      v[CSR_DISP_HASH] = CSR_DW'($urandom & 32'hFFFF);
      v[CSR_PRIO_LO]   = random_prio_word();
      v[CSR_PRIO_HI]   = random_prio_word();
      case (phase)
         0: begin
            // everything cleared
            for (int i = 0; i < 8; i++) v[i] = '0;
         end
         2: begin
            // every flag set, negative priorities: -1 in the low half, -128 in the high half
            v[CSR_LOCKED] = '0;
            for (int i = int'(CSR_PRESERVED); i <= int'(CSR_DISP_HASH); i++)
               v[i] = CSR_DW'(16'hFFFF);
            v[CSR_PRIO_LO] = {8{8'hFF}};
            v[CSR_PRIO_HI] = {8{8'h80}};
         end
         3: begin
            // nothing allocatable
            v[CSR_LOCKED] = CSR_DW'(16'hFFFF);
         end
         4: begin
            // top priority everywhere in the low half
            v[CSR_LOCKED]  = '0;
            v[CSR_PRIO_LO] = {8{8'h7F}};
            v[CSR_PRIO_HI] = '0;
         end
         default: ;
      endcase
      // upper data bits are ignored by the mask registers, drive them anyway
      for (int i = int'(CSR_LOCKED); i <= int'(CSR_DISP_HASH); i++)
         v[i][CSR_DW-1:REG_W] = {$urandom, 16'($urandom)};
      for (int i = 0; i < 8; i++) write_csr(CSR_IDX_W'(i), v[i]);
      settings_applied++;
   endtask

   // ---------------------------------------------------------------------------------------
   // result side: back-pressure and checking
   // ---------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t ns: mismatch in %s, got %0h, expected %0h", $realtime, what, got,
                  want);
   endtask

   // ready changes at the falling edge; one long hold-off when asked for
   always @(negedge clock) begin
      int stall_pct;
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 62 : (idle_mode == IDLE_BOTH) ? 23 : 0;
      if (hold_request && !hold_started) begin
         hold_started = 1'b1;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         result_ready <= 1'b0;
      end else begin
         result_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // every result transfer is compared with the oldest queued expectation
   always @(posedge clock) begin
      alloc_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("result with none pending", 64'(rsp_bus.error_code), 64'd0);
         end else begin
            want = awaited_outcomes.pop_front();
            results_checked++;
            if (rsp_bus.picked_index !== want.picked)
               report_mismatch("picked_index", 64'(rsp_bus.picked_index), 64'(want.picked));
            if (rsp_bus.found !== want.found)
               report_mismatch("found", 64'(rsp_bus.found), 64'(want.found));
            if (rsp_bus.error_code !== want.err)
               report_mismatch("error_code", 64'(rsp_bus.error_code), 64'(want.err));
            if (rsp_bus.addressed_in_use !== want.in_use)
               report_mismatch("addressed_in_use", 64'(rsp_bus.addressed_in_use),
                               64'(want.in_use));
            if (rsp_bus.addressed_grabbed !== want.grabbed)
               report_mismatch("addressed_grabbed", 64'(rsp_bus.addressed_grabbed),
                               64'(want.grabbed));
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      logic [CMD_W-1:0]  cmd;
      logic [IDX_W-1:0]  idx;
      logic [HINT_W-1:0] hint;
      int                directed_count;

      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_CLEAR;
      req_bus.reg_index = '0;
      req_bus.hint_bits = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;

      // directed part, starting from the reset state with all registers zero
      directed_steps.push_back(step_typed(CMD_PICK, 4'd0, 3'd0,
                                          '{4'd0, 1'b1, ERR_OK, 1'b0, 1'b0}));
      directed_steps.push_back(step_cmd(CMD_PICK_UNUSED, 4'd15, 3'd7));
      directed_steps.push_back(step_typed(CMD_ACQUIRE, 4'd0, 3'd0,
                                          '{4'd0, 1'b0, ERR_OK, 1'b1, 1'b0}));
      directed_steps.push_back(step_typed(CMD_ACQUIRE, 4'd0, 3'd0,
                                          '{4'd0, 1'b0, ERR_CONFLICT, 1'b1, 1'b0}));
      directed_steps.push_back(step_cmd(CMD_PICK, 4'd0, 3'd0));
      // discard of a register never acquired
      directed_steps.push_back(step_typed(CMD_DISCARD, 4'd15, 3'd0,
                                          '{4'd0, 1'b0, ERR_CONFLICT, 1'b0, 1'b0}));
      directed_steps.push_back(step_typed(CMD_ACQUIRE, 4'd15, 3'd0,
                                          '{4'd0, 1'b0, ERR_OK, 1'b1, 1'b0}));
      directed_steps.push_back(step_typed(CMD_DISCARD, 4'd15, 3'd0,
                                          '{4'd0, 1'b0, ERR_OK, 1'b0, 1'b0}));
      directed_steps.push_back(step_typed(CMD_GRAB, 4'd3, 3'd0,
                                          '{4'd0, 1'b0, ERR_OK, 1'b0, 1'b1}));
      directed_steps.push_back(step_typed(CMD_GRAB, 4'd3, 3'd0,
                                          '{4'd0, 1'b0, ERR_CONFLICT, 1'b0, 1'b1}));
      directed_steps.push_back(step_cmd(CMD_PICK_UNUSED, 4'd3, 3'd3));
      directed_steps.push_back(step_typed(CMD_UNGRAB, 4'd3, 3'd0,
                                          '{4'd0, 1'b0, ERR_OK, 1'b0, 1'b0}));
      directed_steps.push_back(step_typed(CMD_UNGRAB, 4'd3, 3'd0,
                                          '{4'd0, 1'b0, ERR_CONFLICT, 1'b0, 1'b0}));
      // unused command code does nothing
      directed_steps.push_back(step_typed(CMD_SPARE, 4'd0, 3'd5,
                                          '{4'd0, 1'b0, ERR_OK, 1'b1, 1'b0}));
      directed_steps.push_back(step_typed(CMD_CLEAR, 4'd0, 3'd0,
                                          '{4'd0, 1'b0, ERR_OK, 1'b0, 1'b0}));
      // only registers 0 to 3 left unlocked
      directed_steps.push_back(step_write(CSR_LOCKED, 64'hFFFF_FFFF_FFFF_FFF0));
      directed_steps.push_back(step_typed(CMD_ACQUIRE, 4'd7, 3'd0,
                                          '{4'd0, 1'b0, ERR_CONFLICT, 1'b0, 1'b0}));
      directed_steps.push_back(step_typed(CMD_DISCARD, 4'd7, 3'd0,
                                          '{4'd0, 1'b0, ERR_CONFLICT, 1'b0, 1'b0}));
      for (int r = 0; r < 4; r++) directed_steps.push_back(step_cmd(CMD_ACQUIRE, 4'(r), 3'd0));
      // every free register in use: pick-unused finds none, pick falls back
      directed_steps.push_back(step_typed(CMD_PICK_UNUSED, 4'd2, 3'd0,
                                          '{4'd0, 1'b0, ERR_NONE, 1'b1, 1'b0}));
      directed_steps.push_back(step_typed(CMD_PICK, 4'd2, 3'd4,
                                          '{4'd0, 1'b1, ERR_OK, 1'b1, 1'b0}));
      directed_steps.push_back(step_cmd(CMD_GRAB, 4'd0, 3'd0));
      directed_steps.push_back(step_cmd(CMD_PICK, 4'd0, 3'd7));
      // everything locked
      directed_steps.push_back(step_write(CSR_LOCKED, 64'h0000_0000_0000_FFFF));
      directed_steps.push_back(step_typed(CMD_PICK, 4'd9, 3'd7,
                                          '{4'd0, 1'b0, ERR_NONE, 1'b0, 1'b0}));

      // synchronous reset held at the start, then released at a falling edge
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_write) begin
            wait_for_drain();
            write_csr(directed_steps[i].csr_idx, directed_steps[i].csr_val);
         end else begin
            send_command(directed_steps[i].cmd, directed_steps[i].idx, directed_steps[i].hint,
                         directed_steps[i].typed, directed_steps[i].outcome);
         end
      end
      directed_count = items_sent;

      // random phases, each with its own setting and idle pattern
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_drain();
         apply_setting(phase);
         idle_mode <= idle_mode_type'(phase % 4);
         // long result stall while commands keep coming, so the input backs up
         if (phase == 1) hold_request <= 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            next_random_command(cmd, idx, hint);
            send_command(cmd, idx, hint, 1'b0, '0);
         end
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d commands (%0d directed) under %0d register settings",
               items_sent, directed_count, settings_applied + 2);
      $display("%0d results compared, idle modes none/sender/receiver/both, one long stall",
               results_checked);
      if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("timeout with %0d results still pending", awaited_outcomes.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[files.f]
sv/rca_pkg.sv
sv/rca_req_if.sv
sv/rca_rsp_if.sv
sv/rca_csr.sv
sv/rca_ctrl.sv
sv/rca_dp.sv
sv/register_class_allocator.sv
tb/register_class_allocator_tb.sv
